### sv/hia_pkg.sv
// Shared types, constants and instruction lookup tables for the Hack instruction assembler.
package hia_pkg;

    // Capacity of the comp buffer in characters, and derived widths.
    localparam int MAX_COMP_CHARS = 7;
    localparam int CompBits       = 8 * MAX_COMP_CHARS;
    localparam int CompLenW       = $clog2(MAX_COMP_CHARS + 1);

    // Line queue between the scanner and the encoder.
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCountW    = $clog2(QueueDepth + 1);

    localparam int CompEntries = 28;
    localparam int DestEntries = 8;
    localparam int JumpEntries = 8;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AT    = 8'h40;

    // Longest dest or jump part in characters.
    localparam int ShortPartMax = 3;

    // Input and output beats.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } hia_char_t;

    typedef struct packed {
        logic [15:0] machine_word;
        logic        invalid;
    } hia_word_t;

    // Scanner states.
    typedef enum logic [1:0] {
        LK_START,
        LK_A,
        LK_C,
        LK_C_END
    } line_kind_t;

    typedef enum logic [1:0] {
        PS_FIRST,
        PS_COMP,
        PS_JUMP
    } part_sel_t;

    // One scanned line, handed from the scanner to the encoder.
    typedef struct packed {
        logic                is_a;
        logic [15:0]         number;
        logic                negative;
        logic [CompBits-1:0] comp_text;
        logic [CompLenW-1:0] comp_len;
        logic [23:0]         dest_text;
        logic [1:0]          dest_len;
        logic [23:0]         jump_text;
        logic [1:0]          jump_len;
        logic                overlong;
    } hia_line_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [QCountW-1:0] count;
    } hia_q_status_t;

    // Comp mnemonics, packed right-aligned, with lengths and codes.
    localparam logic [23:0] CompName [CompEntries] = '{
        24'h000030, 24'h000031, 24'h002D31, 24'h000044, 24'h000041,
        24'h002144, 24'h002141, 24'h002D44, 24'h002D41, 24'h442B31,
        24'h412B31, 24'h442D31, 24'h412D31, 24'h442B41, 24'h442D41,
        24'h412D44, 24'h442641, 24'h447C41,
        24'h00004D, 24'h00214D, 24'h002D4D, 24'h4D2B31, 24'h4D2D31,
        24'h442B4D, 24'h442D4D, 24'h4D2D44, 24'h44264D, 24'h447C4D
    };
    localparam logic [1:0] CompLen [CompEntries] = '{
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };
    localparam logic [6:0] CompCode [CompEntries] = '{
        7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F, 7'h33, 7'h1F,
        7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
        7'h70, 7'h71, 7'h73, 7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40, 7'h55
    };

    // Dest and jump mnemonics; the entry index is the encoded field.
    localparam logic [23:0] DestName [DestEntries] = '{
        24'h000000, 24'h00004D, 24'h000044, 24'h004D44,
        24'h000041, 24'h00414D, 24'h004144, 24'h414D44
    };
    localparam logic [1:0] DestLen [DestEntries] = '{
        2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd3
    };
    localparam logic [23:0] JumpName [JumpEntries] = '{
        24'h000000, 24'h4A4754, 24'h4A4551, 24'h4A4745,
        24'h4A4C54, 24'h4A4E45, 24'h4A4C45, 24'h4A4D50
    };
    localparam logic [1:0] JumpLen [JumpEntries] = '{
        2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    // Comp lookup: returns {hit, code}.
    function automatic logic [7:0] comp_lookup(input logic [CompBits-1:0] text,
                                               input logic [CompLenW-1:0] len);
        logic       hit;
        logic [6:0] code;
        hit  = 1'b0;
        code = 7'd0;
        for (int i = 0; i < CompEntries; i++) begin
            if (text == CompBits'(CompName[i]) && len == CompLenW'(CompLen[i])) begin
                hit  = 1'b1;
                code = CompCode[i];
            end
        end
        return {hit, code};
    endfunction

    // Dest lookup: returns {hit, index}.
    function automatic logic [3:0] dest_lookup(input logic [23:0] text,
                                               input logic [1:0] len);
        logic       hit;
        logic [2:0] idx;
        hit = 1'b0;
        idx = 3'd0;
        for (int i = 0; i < DestEntries; i++) begin
            if (text == DestName[i] && len == DestLen[i]) begin
                hit = 1'b1;
                idx = 3'(i);
            end
        end
        return {hit, idx};
    endfunction

    // Jump lookup: returns {hit, index}.
    function automatic logic [3:0] jump_lookup(input logic [23:0] text,
                                               input logic [1:0] len);
        logic       hit;
        logic [2:0] idx;
        hit = 1'b0;
        idx = 3'd0;
        for (int i = 0; i < JumpEntries; i++) begin
            if (text == JumpName[i] && len == JumpLen[i]) begin
                hit = 1'b1;
                idx = 3'(i);
            end
        end
        return {hit, idx};
    endfunction

endpackage

### sv/hia_front.sv
// Character scanner: classifies each line and collects its parts or its number.
module hia_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  hia_pkg::hia_char_t    char_beat,
    input  hia_pkg::hia_q_status_t q_status,
    output logic                  push,
    output hia_pkg::hia_line_t    push_line
);
    import hia_pkg::*;

    line_kind_t          kind_reg, kind_after, kind_next;
    part_sel_t           part_reg, part_after, part_next;
    logic [CompBits-1:0] first_text_reg, first_text_after, first_text_next;
    logic [CompLenW-1:0] first_len_reg, first_len_after, first_len_next;
    logic [23:0]         dest_text_reg, dest_text_after, dest_text_next;
    logic [1:0]          dest_len_reg, dest_len_after, dest_len_next;
    logic [23:0]         jump_text_reg, jump_text_after, jump_text_next;
    logic [1:0]          jump_len_reg, jump_len_after, jump_len_next;
    logic [15:0]         accum_reg, accum_after, accum_next;
    logic                begun_reg, begun_after, begun_next;
    logic                neg_reg, neg_after, neg_next;
    logic                stopped_reg, stopped_after, stopped_next;
    logic                overlong_reg, overlong_after, overlong_next;

    logic       accept;
    logic [7:0] c;
    logic       text_en;
    logic       num_en;
    logic       append;
    logic       is_space;
    logic       is_digit;
    logic       is_sign;

    assign char_stall = q_status.full;
    assign accept     = char_valid && !char_stall;
    assign c          = char_beat.char_code;
    assign push       = accept && char_beat.last_char;

    // Line kind after the current beat.
    always_comb
    begin
        kind_after = kind_reg;
        if (accept)
        begin
            unique case (kind_reg)
                LK_START:
                begin
                    if (c == CH_AT)
                        kind_after = LK_A;
                    else if (c == CH_NUL)
                        kind_after = LK_C_END;
                    else
                        kind_after = LK_C;
                end
                LK_A:     kind_after = LK_A;
                LK_C:     kind_after = (c == CH_NUL) ? LK_C_END : LK_C;
                LK_C_END: kind_after = LK_C_END;
                default:  kind_after = kind_reg;
            endcase
        end
        kind_next = push ? LK_START : kind_after;
    end

    // Which datapath the current beat feeds.
    always_comb
    begin
        text_en = 1'b0;
        num_en  = 1'b0;
        unique case (kind_reg)
            LK_START: text_en = accept && c != CH_AT && c != CH_NUL;
            LK_A:     num_en  = accept;
            LK_C:     text_en = accept && c != CH_NUL;
            LK_C_END: text_en = 1'b0;
            default:  text_en = 1'b0;
        endcase
    end

    assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);

    // Text parts of a C-instruction.
    always_comb
    begin
        part_after       = part_reg;
        first_text_after = first_text_reg;
        first_len_after  = first_len_reg;
        dest_text_after  = dest_text_reg;
        dest_len_after   = dest_len_reg;
        jump_text_after  = jump_text_reg;
        jump_len_after   = jump_len_reg;
        overlong_after   = overlong_reg;
        append           = 1'b0;
        if (text_en)
        begin
            unique case (part_reg)
                PS_FIRST:
                begin
                    if (c == CH_EQ)
                    begin
                        if (first_len_reg > CompLenW'(ShortPartMax))
                            overlong_after = 1'b1;
                        else
                        begin
                            dest_text_after = first_text_reg[23:0];
                            dest_len_after  = first_len_reg[1:0];
                        end
                        first_text_after = '0;
                        first_len_after  = '0;
                        part_after       = PS_COMP;
                    end
                    else if (c == CH_SEMI)
                        part_after = PS_JUMP;
                    else
                        append = 1'b1;
                end
                PS_COMP:
                begin
                    if (c == CH_SEMI)
                        part_after = PS_JUMP;
                    else
                        append = 1'b1;
                end
                PS_JUMP:
                begin
                    if (c == CH_EQ)
                        overlong_after = 1'b1;
                    else if (jump_len_reg < 2'(ShortPartMax))
                    begin
                        jump_text_after = {jump_text_reg[15:0], c};
                        jump_len_after  = jump_len_reg + 2'd1;
                    end
                    else
                        overlong_after = 1'b1;
                end
                default: part_after = part_reg;
            endcase
        end
        // Append to the comp buffer while it has room.
        if (append)
        begin
            if (first_len_reg < CompLenW'(MAX_COMP_CHARS))
            begin
                first_text_after = {first_text_reg[CompBits-9:0], c};
                first_len_after  = first_len_reg + CompLenW'(1);
            end
            else
                overlong_after = 1'b1;
        end
    end

    // Decimal number of an A-instruction.
    always_comb
    begin
        accum_after   = accum_reg;
        begun_after   = begun_reg;
        neg_after     = neg_reg;
        stopped_after = stopped_reg;
        if (num_en && !stopped_reg)
        begin
            if (!begun_reg && is_space)
                begun_after = begun_reg;
            else if (!begun_reg && is_sign)
            begin
                begun_after = 1'b1;
                neg_after   = neg_reg || (c == CH_MINUS);
            end
            else if (is_digit)
            begin
                begun_after = 1'b1;
                accum_after = (accum_reg << 3) + (accum_reg << 1) + {12'd0, c[3:0]};
            end
            else
                stopped_after = 1'b1;
        end
    end

    // Finished line record.
    always_comb
    begin
        push_line.is_a      = (kind_after == LK_A);
        push_line.number    = accum_after;
        push_line.negative  = neg_after;
        push_line.comp_text = first_text_after;
        push_line.comp_len  = first_len_after;
        push_line.dest_text = dest_text_after;
        push_line.dest_len  = dest_len_after;
        push_line.jump_text = jump_text_after;
        push_line.jump_len  = jump_len_after;
        push_line.overlong  = overlong_after;
    end

    // Clear everything after the final character of a line.
    always_comb
    begin
        part_next       = push ? PS_FIRST : part_after;
        first_text_next = push ? '0 : first_text_after;
        first_len_next  = push ? '0 : first_len_after;
        dest_text_next  = push ? '0 : dest_text_after;
        dest_len_next   = push ? '0 : dest_len_after;
        jump_text_next  = push ? '0 : jump_text_after;
        jump_len_next   = push ? '0 : jump_len_after;
        accum_next      = push ? '0 : accum_after;
        begun_next      = push ? 1'b0 : begun_after;
        neg_next        = push ? 1'b0 : neg_after;
        stopped_next    = push ? 1'b0 : stopped_after;
        overlong_next   = push ? 1'b0 : overlong_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= LK_START;
            part_reg       <= PS_FIRST;
            first_text_reg <= '0;
            first_len_reg  <= '0;
            dest_text_reg  <= '0;
            dest_len_reg   <= '0;
            jump_text_reg  <= '0;
            jump_len_reg   <= '0;
            accum_reg      <= '0;
            begun_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            stopped_reg    <= 1'b0;
            overlong_reg   <= 1'b0;
        end
        else
        begin
            kind_reg       <= kind_next;
            part_reg       <= part_next;
            first_text_reg <= first_text_next;
            first_len_reg  <= first_len_next;
            dest_text_reg  <= dest_text_next;
            dest_len_reg   <= dest_len_next;
            jump_text_reg  <= jump_text_next;
            jump_len_reg   <= jump_len_next;
            accum_reg      <= accum_next;
            begun_reg      <= begun_next;
            neg_reg        <= neg_next;
            stopped_reg    <= stopped_next;
            overlong_reg   <= overlong_next;
        end
    end

endmodule

### sv/hia_fifo.sv
// Short queue of scanned lines between the scanner and the encoder.
module hia_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hia_pkg::hia_line_t     push_line,
    input  logic                   pop,
    output hia_pkg::hia_line_t     head_line,
    output hia_pkg::hia_q_status_t q_status
);
    import hia_pkg::*;

    hia_line_t          entry_reg [QueueDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = (count_reg == QCountW'(QueueDepth));
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_line      = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCountW'(do_push) - QCountW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_line;
    end

endmodule

### sv/hia_back.sv
// Encoder: matches the parts of a line against the tables and registers the word.
module hia_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hia_pkg::hia_q_status_t q_status,
    input  hia_pkg::hia_line_t     head_line,
    output logic                   pop,
    output logic                   word_valid,
    input  logic                   word_stall,
    output hia_pkg::hia_word_t     word_beat
);
    import hia_pkg::*;

    logic      word_valid_reg, word_valid_next;
    hia_word_t word_reg;
    hia_word_t encoded;
    logic      load;
    logic [7:0] comp_hit;
    logic [3:0] dest_hit;
    logic [3:0] jump_hit;
    logic       bad;

    // Table matches for the line at the head of the queue.
    assign comp_hit = comp_lookup(head_line.comp_text, head_line.comp_len);
    assign dest_hit = dest_lookup(head_line.dest_text, head_line.dest_len);
    assign jump_hit = jump_lookup(head_line.jump_text, head_line.jump_len);
    assign bad      = head_line.overlong || !comp_hit[7] || !dest_hit[3] || !jump_hit[3];

    // Word assembly.
    always_comb
    begin
        if (head_line.is_a)
        begin
            encoded.machine_word = head_line.negative ? 16'd0 - head_line.number
                                                      : head_line.number;
            encoded.invalid      = 1'b0;
        end
        else if (bad)
        begin
            encoded.machine_word = 16'd0;
            encoded.invalid      = 1'b1;
        end
        else
        begin
            encoded.machine_word = {3'b111, comp_hit[6:0], dest_hit[2:0], jump_hit[2:0]};
            encoded.invalid      = 1'b0;
        end
    end

    // Output register takes a new word whenever it is empty or being drained.
    assign load            = !word_valid_reg || !word_stall;
    assign pop             = load && !q_status.empty;
    assign word_valid_next = load ? !q_status.empty : word_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_valid_reg <= 1'b0;
        else
            word_valid_reg <= word_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            word_reg <= encoded;
    end

    assign word_valid = word_valid_reg;
    assign word_beat  = word_reg;

endmodule

### sv/hack_instruction_assembler.sv
// A finished line goes to the line queue, then its word to the output register.
// Throughput: one character beat per cycle while the line queue is not full, and a
// final character may follow in the next cycle.
// The encoder drains one queued line per cycle into the output register unless stalled.
// Reset: rst_n is asynchronous and active low; it clears the scanner, the line queue
// and the output valid, so a partly received line is dropped.
module hack_instruction_assembler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  hia_pkg::hia_char_t char_beat,
    output logic               word_valid,
    input  logic               word_stall,
    output hia_pkg::hia_word_t word_beat
);
    import hia_pkg::*;

    hia_q_status_t q_status;
    hia_line_t     push_line;
    hia_line_t     head_line;
    logic          push;
    logic          pop;

    // Scanner.
    hia_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .q_status   (q_status),
        .push       (push),
        .push_line  (push_line)
    );

    // Line queue.
    hia_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_line (push_line),
        .pop       (pop),
        .head_line (head_line),
        .q_status  (q_status)
    );

    // Encoder and output register.
    hia_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_line  (head_line),
        .pop        (pop),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_beat  (word_beat)
    );

    // An invalid line always carries a zero word.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_beat.invalid |-> word_beat.machine_word == 16'd0)
        else $error("invalid word is not zero");

    // Queue occupancy stays within its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCountW'(QueueDepth))
        else $error("line queue overflow");

    // A finished line is held in the queue on the next cycle.
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_status.empty)
        else $error("finished line lost");

    // A word only appears when a line was waiting.
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(word_valid) |-> $past(!q_status.empty))
        else $error("word without a queued line");

endmodule
